>>> sv/drs_pkg.sv
// Shared widths, opcodes and result status codes of the DMA range splitter.
package drs_pkg;

  localparam int unsigned NumAreas = 16;
  localparam int unsigned IdxW     = (NumAreas > 1) ? $clog2(NumAreas) : 1;
  localparam int unsigned CntW     = $clog2(NumAreas + 1);

  localparam int unsigned AddrW    = 64;
  localparam int unsigned OffW     = 40;
  localparam int unsigned LenW     = 32;
  localparam int unsigned ChunkW   = 27;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OpW      = 2;

  localparam logic [LenW-1:0] MaxChunk = LenW'(128 * (1 << 20) - 4);

  localparam logic [OpW-1:0] OpClear  = 2'd0;
  localparam logic [OpW-1:0] OpAppend = 2'd1;
  localparam logic [OpW-1:0] OpSplit  = 2'd2;

  localparam logic [StatusW-1:0] StsChunk      = 3'd0;
  localparam logic [StatusW-1:0] StsTableOk    = 3'd1;
  localparam logic [StatusW-1:0] StsMisaligned = 3'd2;
  localparam logic [StatusW-1:0] StsUnmapped   = 3'd3;
  localparam logic [StatusW-1:0] StsBeyond     = 3'd4;
  localparam logic [StatusW-1:0] StsFull       = 3'd5;

endpackage

>>> sv/dma_range_splitter_core.sv
// Steps: clear and append go straight to the result; a split searches the table, checks the
// first piece, walks the following areas, loads the start addresses, then issues chunks.
// The area table entry read and one compare/subtract unit set each step.
// Throughput: one item at a time; the next item is taken once the last result is issued.
// Reset: control state, area count, next start and local_base clear; table entries do not.
module dma_range_splitter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drs_pkg::AddrW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [drs_pkg::OpW-1:0]       opcode_i,
  input  logic                          direction_i,
  input  logic [drs_pkg::AddrW-1:0]     area_address_i,
  input  logic [drs_pkg::OffW-1:0]      area_length_i,
  input  logic [drs_pkg::OffW-1:0]      device_offset_i,
  input  logic [drs_pkg::OffW-1:0]      local_offset_i,
  input  logic [drs_pkg::LenW-1:0]      transfer_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [drs_pkg::AddrW-1:0]     source_address_o,
  output logic [drs_pkg::AddrW-1:0]     dest_address_o,
  output logic [drs_pkg::ChunkW-1:0]    chunk_bytes_o,
  output logic [drs_pkg::StatusW-1:0]   status_o,
  output logic                          last_o
);
  import drs_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StSearch, StFirst, StWalk, StLoad, StEmit, StNext, StResp
  } state_e;

  state_e state_q, state_d;

  logic [OffW-1:0]  start_mem [NumAreas];
  logic [OffW-1:0]  len_mem   [NumAreas];
  logic [AddrW-1:0] addr_mem  [NumAreas];
  logic             tbl_we;

  logic [CntW-1:0]    count_q, count_d, idx_q, idx_d;
  logic [IdxW-1:0]    start_idx_q, start_idx_d;
  logic [OffW-1:0]    next_start_q, next_start_d;
  logic [AddrW-1:0]   local_base_q;
  logic               dir_q, dir_d;
  logic [OffW-1:0]    dev_off_q, dev_off_d, loc_off_q, loc_off_d, in_off_q, in_off_d;
  logic [LenW-1:0]    length_q, length_d, plen0_q, plen0_d, rem_q, rem_d, n_q, n_d;
  logic [AddrW-1:0]   dev_q, dev_d, loc_q, loc_d;
  logic [StatusW-1:0] resp_q, resp_d;

  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [AddrW-1:0]   out_src_q, out_src_d, out_dst_q, out_dst_d;
  logic [ChunkW-1:0]  out_bytes_q, out_bytes_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  logic [IdxW-1:0]  rd_idx;
  logic [OffW-1:0]  rd_start, rd_len, avail;
  logic [AddrW-1:0] rd_addr;
  logic             out_free, hit, fits;
  logic [LenW-1:0]  plen, rem_first, take, chunk;
  logic [1:0]       dev_lo, loc_lo;

  assign rd_idx   = idx_q[IdxW-1:0];
  assign rd_start = start_mem[rd_idx];
  assign rd_len   = len_mem[rd_idx];
  assign rd_addr  = addr_mem[rd_idx];
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == StIdle);

  // Shared compare/subtract datapath, reused by the search, check, walk and emit steps.
  always_comb begin
    hit = (rd_start <= dev_off_q) &&
          ({1'b0, dev_off_q} < ({1'b0, rd_start} + {1'b0, rd_len}));
    avail     = rd_len - in_off_q;
    fits      = ({{(OffW-LenW){1'b0}}, length_q} <= avail);
    plen      = fits ? length_q : avail[LenW-1:0];
    rem_first = fits ? '0 : (length_q - avail[LenW-1:0]);
    dev_lo    = rd_addr[1:0] + in_off_q[1:0];
    loc_lo    = local_base_q[1:0] + loc_off_q[1:0];
    take      = ({{(OffW-LenW){1'b0}}, rem_q} <= rd_len) ? rem_q : rd_len[LenW-1:0];
    chunk     = (n_q < MaxChunk) ? n_q : MaxChunk;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    start_idx_d  = start_idx_q;
    next_start_d = next_start_q;
    dir_d        = dir_q;
    dev_off_d    = dev_off_q;
    loc_off_d    = loc_off_q;
    in_off_d     = in_off_q;
    length_d     = length_q;
    plen0_d      = plen0_q;
    rem_d        = rem_q;
    n_d          = n_q;
    dev_d        = dev_q;
    loc_d        = loc_q;
    resp_d       = resp_q;
    tbl_we       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_src_d    = out_src_q;
    out_dst_d    = out_dst_q;
    out_bytes_d  = out_bytes_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          dir_d     = direction_i;
          dev_off_d = device_offset_i;
          loc_off_d = local_offset_i;
          length_d  = transfer_length_i;
          unique case (opcode_i)
            OpClear: begin
              count_d      = '0;
              next_start_d = '0;
              resp_d       = StsTableOk;
              state_d      = StResp;
            end
            OpAppend: begin
              if (count_q >= CntW'(NumAreas)) begin
                resp_d = StsFull;
              end else begin
                tbl_we       = 1'b1;
                count_d      = count_q + 1'b1;
                next_start_d = next_start_q + area_length_i;
                resp_d       = StsTableOk;
              end
              state_d = StResp;
            end
            OpSplit: begin
              if (transfer_length_i == '0) begin
                resp_d  = StsChunk;
                state_d = StResp;
              end else begin
                idx_d   = '0;
                state_d = StSearch;
              end
            end
            default: ;  // unused opcode: drop the item
          endcase
        end
      end
      StSearch: begin
        if (idx_q == count_q) begin
          resp_d  = StsUnmapped;
          state_d = StResp;
        end else if (hit) begin
          start_idx_d = rd_idx;
          in_off_d    = dev_off_q - rd_start;
          state_d     = StFirst;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StFirst: begin
        plen0_d = plen;
        rem_d   = rem_first;
        if (dev_lo != 2'd0 || loc_lo != 2'd0 || plen[1:0] != 2'd0) begin
          resp_d  = StsMisaligned;
          state_d = StResp;
        end else if (rem_first == '0) begin
          state_d = StLoad;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (idx_q >= count_q) begin
          resp_d  = StsBeyond;
          state_d = StResp;
        end else if (rd_addr[1:0] != 2'd0 || take[1:0] != 2'd0) begin
          resp_d  = StsMisaligned;
          state_d = StResp;
        end else if (take == rem_q) begin
          idx_d   = CntW'(start_idx_q);
          state_d = StLoad;
        end else begin
          rem_d = rem_q - take;
          idx_d = idx_q + 1'b1;
        end
      end
      StLoad: begin
        dev_d   = rd_addr + AddrW'(in_off_q);
        loc_d   = local_base_q + AddrW'(loc_off_q);
        n_d     = plen0_q;
        rem_d   = length_q;
        state_d = StEmit;
      end
      StEmit: begin
        if (n_q == '0) begin
          // piece used up: advance to the next area
          idx_d   = idx_q + 1'b1;
          state_d = StNext;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_src_d    = dir_q ? loc_q : dev_q;
          out_dst_d    = dir_q ? dev_q : loc_q;
          out_bytes_d  = chunk[ChunkW-1:0];
          out_status_d = StsChunk;
          out_last_d   = (chunk == rem_q);
          dev_d        = dev_q + AddrW'(chunk);
          loc_d        = loc_q + AddrW'(chunk);
          n_d          = n_q - chunk;
          rem_d        = rem_q - chunk;
          if (chunk == rem_q) begin
            state_d = StIdle;
          end
        end
      end
      StNext: begin
        dev_d   = rd_addr;
        n_d     = take;
        state_d = StEmit;
      end
      StResp: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_src_d    = '0;
          out_dst_d    = '0;
          out_bytes_d  = '0;
          out_status_d = resp_q;
          out_last_d   = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      next_start_q <= '0;
      local_base_q <= '0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      next_start_q <= next_start_d;
      if (cfg_we_i) begin
        local_base_q <= cfg_wdata_i;
      end
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_idx_q  <= start_idx_d;
    dir_q        <= dir_d;
    dev_off_q    <= dev_off_d;
    loc_off_q    <= loc_off_d;
    in_off_q     <= in_off_d;
    length_q     <= length_d;
    plen0_q      <= plen0_d;
    rem_q        <= rem_d;
    n_q          <= n_d;
    dev_q        <= dev_d;
    loc_q        <= loc_d;
    resp_q       <= resp_d;
    out_src_q    <= out_src_d;
    out_dst_q    <= out_dst_d;
    out_bytes_q  <= out_bytes_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      start_mem[count_q[IdxW-1:0]] <= next_start_q;
      len_mem[count_q[IdxW-1:0]]   <= area_length_i;
      addr_mem[count_q[IdxW-1:0]]  <= area_address_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign source_address_o = out_src_q;
  assign dest_address_o   = out_dst_q;
  assign chunk_bytes_o    = out_bytes_q;
  assign status_o         = out_status_q;
  assign last_o           = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NumAreas))
    else $error("area count exceeds table depth");

  a_non_chunk_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StsChunk |-> last_o && chunk_bytes_o == '0)
    else $error("non-chunk result not final or carries bytes");

  a_mid_chunk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == StsChunk && chunk_bytes_o != '0)
    else $error("non-final result is not a real chunk");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> !in_ready_o)
    else $error("input taken while chunks are being issued");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for dma_range_splitter_core: random table/split traffic and result checks.
`timescale 1ns / 1ps

module tb_top;
  import drs_pkg::*;

  localparam int          ClkPeriod   = 10;
  localparam int          ResetCycles = 8;
  localparam int          CycleLimit  = 400000;
  localparam int          DrainCycles = 64;
  localparam int          HoldCycles  = 400;
  localparam int          MaxResults  = 64;
  localparam logic [63:0] Mask40      = 64'hFF_FFFF_FFFF;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic            direction;
    logic [AddrW-1:0] area_address;
    logic [OffW-1:0] area_length;
    logic [OffW-1:0] device_offset;
    logic [OffW-1:0] local_offset;
    logic [LenW-1:0] transfer_length;
  } xfer_req_t;

  typedef struct packed {
    logic [AddrW-1:0]   src;
    logic [AddrW-1:0]   dst;
    logic [ChunkW-1:0]  bytes;
    logic [StatusW-1:0] status;
    logic               last;
  } dma_result_t;

  // Area table mirror, chunk splitter and queue of results still due from the block.
  class split_scoreboard;
    dma_result_t due_results[$];
    int          errors;
    int          n_requests;
    int          n_results;
    int          status_count[8];
    logic [63:0] local_base;
    logic [63:0] a_start[NumAreas];
    logic [63:0] a_len[NumAreas];
    logic [63:0] a_addr[NumAreas];
    int          count;
    logic [OffW-1:0] next_start;

    function new();
      errors     = 0;
      n_requests = 0;
      n_results  = 0;
      local_base = '0;
      count      = 0;
      next_start = '0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_base(logic [63:0] v);
      local_base = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void expect_result(dma_result_t res);
      due_results.insert(due_results.size(), res);
      status_count[res.status]++;
    endfunction

    function void expect_status(logic [StatusW-1:0] sts);
      dma_result_t res;
      res        = '0;
      res.status = sts;
      res.last   = 1'b1;
      expect_result(res);
    endfunction

    function bit misaligned(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      return (a[1:0] | b[1:0] | c[1:0]) != 2'b00;
    endfunction

    function void predict_split(xfer_req_t r);
      logic [63:0] len, dev, in_off, remaining, loc, take, chunk, d, l, n;
      logic [63:0] pdev[NumAreas];
      logic [63:0] ploc[NumAreas];
      logic [63:0] plen[NumAreas];
      dma_result_t held;
      bit          have_held;
      int          hit, np, i, emitted;
      len = 64'(r.transfer_length);
      dev = 64'(r.device_offset);
      // zero length completes at once, even with no table
      if (len == 0) begin
        expect_status(StsChunk);
        return;
      end
      hit = -1;
      for (i = 0; i < count; i++)
        if (hit < 0 && a_start[i] <= dev && dev < a_start[i] + a_len[i]) hit = i;
      if (hit < 0) begin
        expect_status(StsUnmapped);
        return;
      end
      in_off  = dev - a_start[hit];
      loc     = local_base + 64'(r.local_offset);
      pdev[0] = a_addr[hit] + in_off;
      ploc[0] = loc;
      if (in_off + len <= a_len[hit]) begin
        plen[0]   = len;
        remaining = 0;
      end else begin
        plen[0]   = a_len[hit] - in_off;
        remaining = len - plen[0];
      end
      if (misaligned(pdev[0], ploc[0], plen[0])) begin
        expect_status(StsMisaligned);
        return;
      end
      loc += plen[0];
      np = 1;
      // take whole following areas until the rest fits
      for (i = hit + 1; remaining != 0; i++) begin
        if (i >= count) begin
          expect_status(StsBeyond);
          return;
        end
        take     = (a_len[i] >= remaining) ? remaining : a_len[i];
        pdev[np] = a_addr[i];
        ploc[np] = loc;
        plen[np] = take;
        if (misaligned(a_addr[i], loc, take)) begin
          expect_status(StsMisaligned);
          return;
        end
        np++;
        loc       += take;
        remaining -= take;
      end
      // hold back each chunk by one so the final one can carry last
      have_held = 1'b0;
      emitted   = 0;
      held      = '0;
      for (i = 0; i < np; i++) begin
        d = pdev[i];
        l = ploc[i];
        n = plen[i];
        while (n != 0 && emitted < MaxResults) begin
          if (have_held) expect_result(held);
          chunk       = (n < 64'(MaxChunk)) ? n : 64'(MaxChunk);
          held.src    = r.direction ? l : d;
          held.dst    = r.direction ? d : l;
          held.bytes  = chunk[ChunkW-1:0];
          held.status = StsChunk;
          held.last   = 1'b0;
          have_held   = 1'b1;
          emitted++;
          d += chunk;
          l += chunk;
          n -= chunk;
        end
      end
      if (!have_held) begin
        expect_status(StsChunk);
      end else begin
        held.last = 1'b1;
        expect_result(held);
      end
    endfunction

    function void note_request(xfer_req_t r);
      n_requests++;
      case (r.opcode)
        OpClear: begin
          count      = 0;
          next_start = '0;
          expect_status(StsTableOk);
        end
        OpAppend: begin
          if (count >= NumAreas) begin
            expect_status(StsFull);
          end else begin
            a_start[count] = 64'(next_start);
            a_len[count]   = 64'(r.area_length);
            a_addr[count]  = r.area_address;
            count++;
            next_start = next_start + r.area_length;
            expect_status(StsTableOk);
          end
        end
        OpSplit: predict_split(r);
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [63:0] e, logic [63:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, g);
      end
    endfunction

    function void check_result(dma_result_t got);
      dma_result_t want;
      n_results++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: src %h dst %h bytes %h status %0d last %b",
                 $time, got.src, got.dst, got.bytes, got.status, got.last);
        return;
      end
      want = due_results.pop_front();
      compare("source_address", want.src, got.src);
      compare("dest_address", want.dst, got.dst);
      compare("chunk_bytes", 64'(want.bytes), 64'(got.bytes));
      compare("status", 64'(want.status), 64'(got.status));
      compare("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [AddrW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OpW-1:0]      opcode_i;
  logic                direction_i;
  logic [AddrW-1:0]    area_address_i;
  logic [OffW-1:0]     area_length_i;
  logic [OffW-1:0]     device_offset_i;
  logic [OffW-1:0]     local_offset_i;
  logic [LenW-1:0]     transfer_length_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [AddrW-1:0]    source_address_o;
  logic [AddrW-1:0]    dest_address_o;
  logic [ChunkW-1:0]   chunk_bytes_o;
  logic [StatusW-1:0]  status_o;
  logic                last_o;

  split_scoreboard sb;
  bit              burst_mode = 1'b0;
  bit              hold_req = 1'b0;
  int              items_sent = 0;
  int              base_writes = 0;
  int              cycle_count = 0;

  dma_range_splitter_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .direction_i       (direction_i),
    .area_address_i    (area_address_i),
    .area_length_i     (area_length_i),
    .device_offset_i   (device_offset_i),
    .local_offset_i    (local_offset_i),
    .transfer_length_i (transfer_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .source_address_o  (source_address_o),
    .dest_address_o    (dest_address_o),
    .chunk_bytes_o     (chunk_bytes_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic xfer_req_t make_req(logic [OpW-1:0] op, logic dir, logic [AddrW-1:0] addr,
                                         logic [OffW-1:0] alen, logic [OffW-1:0] dev,
                                         logic [OffW-1:0] loc, logic [LenW-1:0] len);
    xfer_req_t r;
    r.opcode          = op;
    r.direction       = dir;
    r.area_address    = addr;
    r.area_length     = alen;
    r.device_offset   = dev;
    r.local_offset    = loc;
    r.transfer_length = len;
    return r;
  endfunction

  function automatic xfer_req_t noise_item();
    return make_req(OpW'($urandom_range(0, 3)), 1'($urandom), rand64(), OffW'(rand64()),
                    OffW'(rand64()), OffW'(rand64()), $urandom);
  endfunction

  function automatic logic [AddrW-1:0] pick_area_address();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return rand64() & ~64'h3;
    if (sel < 92) return 64'hFFFF_FFFF_FFFF_FFFC - 64'($urandom_range(0, 255)) * 4;
    return rand64();
  endfunction

  function automatic logic [OffW-1:0] pick_area_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return OffW'($urandom_range(1, 64) * 4);
    if (sel < 85) return OffW'($urandom & 32'hFFFF_FFFC);
    if (sel < 90) return '0;
    if (sel < 95) return OffW'($urandom_range(1, 256));
    return OffW'(rand64());
  endfunction

  // Offer one item, idling first now and then; valid stays up until taken.
  task automatic send_item(input xfer_req_t r);
    if (!burst_mode && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= r.opcode;
    direction_i       <= r.direction;
    area_address_i    <= r.area_address;
    area_length_i     <= r.area_length;
    device_offset_i   <= r.device_offset;
    local_offset_i    <= r.local_offset;
    transfer_length_i <= r.transfer_length;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    if (r.opcode != OpUnused) items_sent++;
  endtask

  // Drain all results, let the block settle, then load a new local base.
  task automatic write_base(input logic [63:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_base(v);
    base_writes++;
  endtask

  // Clear, map a few areas, then split transfers aimed at them.
  task automatic table_sequence(input bit fill_table);
    logic [63:0] starts[NumAreas];
    logic [63:0] lens[NumAreas];
    logic [63:0] total, off_in, span, len, room;
    int          n_app, n_map, n_split, k, kind, i;
    xfer_req_t   r;
    r        = noise_item();
    r.opcode = OpClear;
    send_item(r);
    n_map = 0;
    total = '0;
    if (fill_table) n_app = NumAreas + 2;
    else if ($urandom_range(0, 9) == 0) n_app = $urandom_range(12, 18);
    else n_app = $urandom_range(1, 8);
    for (i = 0; i < n_app; i++) begin
      r              = noise_item();
      r.opcode       = OpAppend;
      r.area_address = pick_area_address();
      r.area_length  = pick_area_length();
      if (n_map < NumAreas) begin
        starts[n_map] = total;
        lens[n_map]   = 64'(r.area_length);
        total         = (total + lens[n_map]) & Mask40;
        n_map++;
      end
      send_item(r);
    end
    n_split = $urandom_range(2, 7);
    for (i = 0; i < n_split; i++) begin
      r               = noise_item();
      r.opcode        = OpSplit;
      k               = $urandom_range(0, n_map - 1);
      off_in          = (lens[k] == 0) ? 64'h0 : ((rand64() % lens[k]) & ~64'h3);
      r.device_offset = OffW'(starts[k] + off_in);
      r.local_offset  = OffW'(rand64() & ~64'h3);
      span            = total - (starts[k] + off_in);
      room            = lens[k] - off_in;
      kind            = $urandom_range(0, 99);
      if (kind < 45) begin
        len = (room < 4) ? 64'h4 : ((rand64() % room) & ~64'h3) + 4;
      end else if (kind < 75) begin
        len = (rand64() % (span + 1)) & ~64'h3;
      end else if (kind < 82) begin
        len = span + 64'($urandom_range(1, 16)) * 4;
      end else if (kind < 87) begin
        len = 0;
      end else if (kind < 93) begin
        len = 64'($urandom_range(1, 64)) * 4;
        case ($urandom_range(0, 2))
          0: len = len | 64'($urandom_range(1, 3));
          1: r.device_offset = r.device_offset + OffW'($urandom_range(1, 3));
          default: r.local_offset = r.local_offset | OffW'($urandom_range(1, 3));
        endcase
      end else begin
        r.device_offset = OffW'(total + 64'($urandom_range(0, 4095)));
        len             = 64'($urandom_range(1, 64)) * 4;
      end
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFC;
      r.transfer_length = LenW'(len);
      send_item(r);
    end
  endtask

  task automatic random_phase(input int target, input bit fill_first);
    bit fill;
    int n, j;
    fill = fill_first;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 3);
        for (j = 0; j < n; j++) send_item(noise_item());
      end else begin
        table_sequence(fill);
        fill = 1'b0;
      end
    end
  endtask

  // Result side: random back-pressure, or one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= burst_mode || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({source_address_o, dest_address_o, chunk_bytes_o, status_o, last_o});
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    opcode_i          <= OpClear;
    direction_i       <= 1'b0;
    area_address_i    <= '0;
    area_length_i     <= '0;
    device_offset_i   <= '0;
    local_offset_i    <= '0;
    transfer_length_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_base(64'h0);

    // empty table: zero length still completes, anything else is unmapped
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpSplit, 1'b1, 64'h0, 40'h0, 40'h10, 40'h0, 32'h4));
    send_item(make_req(OpAppend, 1'b0, 64'h1000, 40'h100, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpAppend, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 40'h200, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpAppend, 1'b0, 64'h8000_0000, 40'h2_0000_0000, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpAppend, 1'b0, 64'h3, 40'h0, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpAppend, 1'b0, 64'hFFFF_FFFF_FFFF_FFFC, 40'hFF_FFFF_FFFF,
                       40'h0, 40'h0, 32'h0));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h10, 40'h40, 32'h80));
    // crosses three areas and cuts the big one at the chunk limit
    send_item(make_req(OpSplit, 1'b1, 64'h0, 40'h0, 40'h80, 40'h0, 32'hFFFF_FFFC));
    // runs into the zero-length area at an odd address
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h2_0000_0200, 40'h0, 32'h200));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h4, 40'h0, 32'h6));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h2, 40'h0, 32'h8));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h0, 40'h1, 32'h8));
    send_item(make_req(OpSplit, 1'b1, 64'h0, 40'h0, 40'h2_0000_0400, 40'hFF_FFFF_FFFC,
                       32'h1000_0000));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'hFF_FFFF_FFFF, 40'h0, 32'h4));
    send_item(make_req(OpUnused, 1'b1, '1, '1, '1, '1, '1));
    send_item(make_req(OpClear, 1'b0, 64'h0, 40'h0, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpAppend, 1'b0, 64'h4000, 40'h40, 40'h0, 40'h0, 32'h0));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h40, 40'h0, 32'h4));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h20, 40'h0, 32'h40));
    send_item(make_req(OpSplit, 1'b0, 64'h0, 40'h0, 40'h0, 40'h0, 32'hFFFF_FFFF));
    send_item(make_req(OpSplit, 1'b1, 64'h0, 40'h0, 40'h0, 40'h100, 32'h40));

    // local addresses wrap; results held off long enough to back up the input
    write_base(64'hFFFF_FFFF_FFFF_FF00);
    hold_req = 1'b1;
    random_phase(90, 1'b1);
    write_base(rand64() & ~64'h3);
    burst_mode = 1'b1;
    random_phase(165, 1'b0);
    write_base('1);
    burst_mode = 1'b0;
    random_phase(190, 1'b0);
    write_base(rand64());
    random_phase(255, 1'b0);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d items (%0d results) over %0d local base settings in %0d cycles.",
             sb.n_requests, sb.n_results, base_writes, cycle_count);
    $display("Chunks %0d, table updates %0d, misaligned %0d, unmapped %0d, beyond %0d, full %0d.",
             sb.status_count[StsChunk], sb.status_count[StsTableOk],
             sb.status_count[StsMisaligned], sb.status_count[StsUnmapped],
             sb.status_count[StsBeyond], sb.status_count[StsFull]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
